FILE: sv/expression_char_lexer_core_assert.svh
// ----------------------------------------------------------------------------
// Expression character lexer assertion macros
// Concurrent check macros used by the lexer core RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef EXPRESSION_CHAR_LEXER_CORE_ASSERT_SVH
`define EXPRESSION_CHAR_LEXER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off during reset.
`define ECL_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lexer check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ECL_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lexer check failed");

`else

`define ECL_ASSERT_IMPL(name, ante, cons)
`define ECL_ASSERT_NEXT(name, ante, cons)

`endif

`endif

FILE: sv/ecl_pkg.sv
// ----------------------------------------------------------------------------
// Expression character lexer package
// Token kinds, forms, complaint codes, character sets and the rule table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ecl_pkg;

    localparam int ECL_COLUMN_BITS = 16;
    localparam int ECL_QUEUE_DEPTH = 4;
    localparam int COL_W           = 16;

    typedef logic [4:0] kind_t;
    typedef logic [1:0] form_t;
    typedef logic [4:0] err_t;
    typedef logic [4:0] flags_t;

    // Token kinds
    localparam kind_t KIND_NONE       = 5'd0;
    localparam kind_t KIND_TEXT       = 5'd1;
    localparam kind_t KIND_NUMSTR     = 5'd2;
    localparam kind_t KIND_OPER       = 5'd3;
    localparam kind_t KIND_ACCESSOR   = 5'd4;
    localparam kind_t KIND_DELIM      = 5'd5;
    localparam kind_t KIND_ARG_START  = 5'd6;
    localparam kind_t KIND_ARG_END    = 5'd7;
    localparam kind_t KIND_IND_START  = 5'd8;
    localparam kind_t KIND_IND_END    = 5'd9;
    localparam kind_t KIND_CTRL_START = 5'd10;
    localparam kind_t KIND_CTRL_END   = 5'd11;
    localparam kind_t KIND_PIPE       = 5'd12;
    localparam kind_t KIND_PIPE_RES   = 5'd13;
    localparam kind_t KIND_SPREAD     = 5'd14;
    localparam kind_t KIND_STMT_END   = 5'd15;
    localparam kind_t KIND_SOFT_END   = 5'd16;

    // Token forms
    localparam form_t FORM_PLAIN  = 2'd0;
    localparam form_t FORM_INT    = 2'd1;
    localparam form_t FORM_FLOAT  = 2'd2;
    localparam form_t FORM_STRING = 2'd3;

    // Complaint codes, named by the previous token kind; ERR_DOT marks a second dot
    localparam err_t ERR_NONE       = 5'd0;
    localparam err_t ERR_TEXT       = 5'd1;
    localparam err_t ERR_NUMSTR     = 5'd2;
    localparam err_t ERR_OPER       = 5'd3;
    localparam err_t ERR_ACCESSOR   = 5'd4;
    localparam err_t ERR_DELIM      = 5'd5;
    localparam err_t ERR_ARG_START  = 5'd6;
    localparam err_t ERR_CLOSER     = 5'd7;
    localparam err_t ERR_IND_START  = 5'd8;
    localparam err_t ERR_IND_END    = 5'd9;
    localparam err_t ERR_CTRL_START = 5'd10;
    localparam err_t ERR_PIPE       = 5'd11;
    localparam err_t ERR_PIPE_RES   = 5'd12;
    localparam err_t ERR_SPREAD     = 5'd13;
    localparam err_t ERR_STMT_END   = 5'd14;
    localparam err_t ERR_SOFT_END   = 5'd15;
    localparam err_t ERR_DOT        = 5'd16;

    // Rule flags: which classes may follow a kind
    localparam flags_t FL_OP  = 5'b00001;
    localparam flags_t FL_DG  = 5'b00010;
    localparam flags_t FL_WD  = 5'b00100;
    localparam flags_t FL_TXT = 5'b01000;
    localparam flags_t FL_NUM = 5'b10000;

    // Special characters
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DOT    = 8'h2E;

    typedef struct packed {
        flags_t      flags;
        logic [11:0] mask;   // singulars allowed next, bit n = singular n
        err_t        err;
    } rule_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] idx;
    } sing_t;

    // One queue entry: the character result and an optional flush result
    typedef struct packed {
        logic             append;
        logic             end_token;
        kind_t            end_kind;
        form_t            end_form;
        kind_t            char_kind;
        logic             error;
        err_t             error_code;
        logic [COL_W-1:0] column;
        logic             has_flush;
        kind_t            flush_kind;
        form_t            flush_form;
    } ecl_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ecl_qstat_t;

    function automatic rule_t rule_of(kind_t k);
        rule_t r;
        case (k)
            KIND_TEXT:       r = '{FL_TXT, 12'h9FF, ERR_TEXT};
            KIND_NUMSTR:     r = '{FL_NUM, 12'h9EB, ERR_NUMSTR};
            KIND_OPER:       r = '{FL_OP | FL_DG | FL_WD, 12'hE57, ERR_OPER};
            KIND_ACCESSOR:   r = '{FL_WD, 12'h000, ERR_ACCESSOR};
            KIND_DELIM:      r = '{FL_OP | FL_DG | FL_WD, 12'h61C, ERR_DELIM};
            KIND_ARG_START:  r = '{FL_OP | FL_DG | FL_WD, 12'h61C, ERR_ARG_START};
            KIND_ARG_END:    r = '{FL_OP | FL_WD, 12'h9FF, ERR_CLOSER};
            KIND_IND_START:  r = '{FL_OP | FL_DG | FL_WD, 12'h677, ERR_IND_START};
            KIND_IND_END:    r = '{FL_OP, 12'hDFF, ERR_IND_END};
            KIND_CTRL_START: r = '{FL_OP | FL_DG | FL_WD, 12'h794, ERR_CTRL_START};
            KIND_CTRL_END:   r = '{FL_OP | FL_WD, 12'h9FF, ERR_CLOSER};
            KIND_PIPE:       r = '{FL_OP | FL_DG | FL_WD, 12'h614, ERR_PIPE};
            KIND_PIPE_RES:   r = '{FL_OP, 12'hBFF, ERR_PIPE_RES};
            KIND_SPREAD:     r = '{FL_WD, 12'h257, ERR_SPREAD};
            KIND_STMT_END:   r = '{FL_OP | FL_DG | FL_WD, 12'hCD4, ERR_STMT_END};
            KIND_SOFT_END:   r = '{FL_OP | FL_DG | FL_WD, 12'hFFF, ERR_SOFT_END};
            default:         r = '{FL_OP | FL_DG | FL_WD, 12'h414, ERR_NONE};
        endcase
        return r;
    endfunction

    // Singular set: . , ( ) [ ] { } | & ~ ;
    function automatic sing_t sing_of(logic [7:0] c);
        sing_t s;
        case (c)
            8'h2E:   s = '{1'b1, 4'd0};
            8'h2C:   s = '{1'b1, 4'd1};
            8'h28:   s = '{1'b1, 4'd2};
            8'h29:   s = '{1'b1, 4'd3};
            8'h5B:   s = '{1'b1, 4'd4};
            8'h5D:   s = '{1'b1, 4'd5};
            8'h7B:   s = '{1'b1, 4'd6};
            8'h7D:   s = '{1'b1, 4'd7};
            8'h7C:   s = '{1'b1, 4'd8};
            8'h26:   s = '{1'b1, 4'd9};
            8'h7E:   s = '{1'b1, 4'd10};
            8'h3B:   s = '{1'b1, 4'd11};
            default: s = '{1'b0, 4'd0};
        endcase
        return s;
    endfunction

    // Operator set: + - * ! / = > < @
    function automatic logic is_op(logic [7:0] c);
        return (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2A) || (c == 8'h21) ||
               (c == 8'h2F) || (c == 8'h3D) || (c == 8'h3E) || (c == 8'h3C) ||
               (c == 8'h40);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // Word set: letters, underscore, colon
    function automatic logic is_word(logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               (c == 8'h5F) || (c == 8'h3A);
    endfunction

    function automatic form_t form_of(kind_t k, logic dot);
        if (k == KIND_NUMSTR)
        begin
            return dot ? FORM_FLOAT : FORM_INT;
        end
        return FORM_PLAIN;
    endfunction

endpackage

FILE: sv/ecl_front.sv
// ----------------------------------------------------------------------------
// Lexer front end
// Accepts characters, classifies them against the previous token and
// writes one queue entry per character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecl_front #(
    parameter int COLUMN_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        ch,
    input  logic              last,
    input  ecl_pkg::ecl_qstat_t qstat,
    output logic              wr_en,
    output ecl_pkg::ecl_rec_t wr_rec
);
    import ecl_pkg::*;

    kind_t                  cur_kind_reg, cur_kind_next;
    logic                   tok_ne_reg, tok_ne_next;
    logic                   dot_reg, dot_next;
    logic                   after_ws_reg, after_ws_next;
    logic                   in_str_reg, in_str_next;
    logic                   prior_bs_reg, prior_bs_next;
    logic                   err_lat_reg, err_lat_next;
    logic [COLUMN_BITS-1:0] pos_reg, pos_next, pos_inc;
    logic [COL_W-1:0]       col;

    logic  cls_ok;
    kind_t cls_kind;
    err_t  cls_err;

    assign in_stall = qstat.full;
    assign wr_en    = in_valid && !qstat.full;
    assign pos_inc  = (pos_reg != '1) ? pos_reg + 1'b1 : pos_reg;

    generate
        if (COLUMN_BITS > COL_W)
        begin : g_col_sat
            assign col = (|pos_inc[COLUMN_BITS-1:COL_W]) ? '1 : pos_inc[COL_W-1:0];
        end
        else
        begin : g_col_ext
            assign col = COL_W'(pos_inc);
        end
    endgenerate

    // Classification of ch after the current kind
    always_comb
    begin
        rule_t r;
        sing_t sg;
        logic  decided;
        r        = rule_of(cur_kind_reg);
        sg       = sing_of(ch);
        decided  = 1'b1;
        cls_ok   = 1'b1;
        cls_kind = KIND_NONE;
        cls_err  = r.err;
        if ((ch == CH_SPACE) || (ch == CH_TAB))
        begin
            cls_kind = KIND_NONE;
        end
        else if (ch == CH_NL)
        begin
            cls_kind = KIND_SOFT_END;
        end
        else if ((r.flags & FL_NUM) != '0)
        begin
            if ((ch == CH_DOT) && dot_reg)
            begin
                cls_ok  = 1'b0;
                cls_err = ERR_DOT;
            end
            else if (is_digit(ch) || (ch == CH_DOT))
                cls_kind = KIND_NUMSTR;
            else if (is_op(ch))
                cls_kind = KIND_OPER;
            else
                decided = 1'b0;
        end
        else if ((r.flags & FL_TXT) != '0)
        begin
            if (after_ws_reg && is_digit(ch))
                cls_kind = KIND_NUMSTR;
            else if (is_word(ch) || is_digit(ch))
                cls_kind = KIND_TEXT;
            else if (is_op(ch))
                cls_kind = KIND_OPER;
            else
                decided = 1'b0;
        end
        else
        begin
            if (((r.flags & FL_OP) != '0) && is_op(ch))
                cls_kind = KIND_OPER;
            else if (((r.flags & FL_DG) != '0) && is_digit(ch))
                cls_kind = KIND_NUMSTR;
            else if (((r.flags & FL_WD) != '0) && is_word(ch))
                cls_kind = KIND_TEXT;
            else
                decided = 1'b0;
        end
        if (!decided)
        begin
            if (sg.hit && r.mask[sg.idx])
                cls_kind = KIND_ACCESSOR + kind_t'(sg.idx);
            else
                cls_ok = 1'b0;
        end
    end

    // State update and queue entry
    always_comb
    begin
        sing_t sg;
        sg            = sing_of(ch);
        cur_kind_next = cur_kind_reg;
        tok_ne_next   = tok_ne_reg;
        dot_next      = dot_reg;
        after_ws_next = after_ws_reg;
        in_str_next   = in_str_reg;
        err_lat_next  = err_lat_reg;
        prior_bs_next = (ch == CH_BSLASH);
        pos_next      = pos_inc;
        wr_rec        = '0;
        wr_rec.column = col;

        if (!err_lat_reg)
        begin
            if ((ch == CH_QUOTE) && !in_str_reg)
            begin
                if (tok_ne_reg)
                begin
                    wr_rec.end_token = 1'b1;
                    wr_rec.end_kind  = cur_kind_reg;
                    wr_rec.end_form  = form_of(cur_kind_reg, dot_reg);
                end
                in_str_next      = 1'b1;
                cur_kind_next    = KIND_NUMSTR;
                tok_ne_next      = 1'b0;
                dot_next         = 1'b0;
                wr_rec.char_kind = KIND_NUMSTR;
            end
            else if ((ch == CH_QUOTE) && in_str_reg && !prior_bs_reg)
            begin
                in_str_next      = 1'b0;
                wr_rec.end_token = 1'b1;
                wr_rec.end_kind  = KIND_NUMSTR;
                wr_rec.end_form  = FORM_STRING;
                tok_ne_next      = 1'b0;
                dot_next         = 1'b0;
                wr_rec.char_kind = KIND_NUMSTR;
            end
            else if (in_str_reg)
            begin
                wr_rec.char_kind = KIND_NUMSTR;
                if (ch != CH_BSLASH)
                begin
                    wr_rec.append = 1'b1;
                    tok_ne_next   = 1'b1;
                    if (ch == CH_DOT)
                        dot_next = 1'b1;
                end
            end
            else if (!cls_ok)
            begin
                wr_rec.error      = 1'b1;
                wr_rec.error_code = cls_err;
                err_lat_next      = 1'b1;
            end
            else if (cls_kind == KIND_NONE)
            begin
                after_ws_next = 1'b1;
                if (tok_ne_reg)
                begin
                    wr_rec.end_token = 1'b1;
                    wr_rec.end_kind  = cur_kind_reg;
                    wr_rec.end_form  = form_of(cur_kind_reg, dot_reg);
                    tok_ne_next      = 1'b0;
                    dot_next         = 1'b0;
                end
            end
            else
            begin
                after_ws_next = 1'b0;
                if (((cls_kind != cur_kind_reg) || (sg.hit && (ch != CH_DOT))) &&
                    (cur_kind_reg != KIND_NONE) && tok_ne_reg)
                begin
                    wr_rec.end_token = 1'b1;
                    wr_rec.end_kind  = cur_kind_reg;
                    wr_rec.end_form  = form_of(cur_kind_reg, dot_reg);
                    dot_next         = 1'b0;
                end
                cur_kind_next    = cls_kind;
                tok_ne_next      = 1'b1;
                if (ch == CH_DOT)
                    dot_next = 1'b1;
                wr_rec.append    = 1'b1;
                wr_rec.char_kind = cls_kind;
            end
        end

        if (last)
        begin
            if (!err_lat_next && tok_ne_next)
            begin
                wr_rec.has_flush  = 1'b1;
                wr_rec.flush_kind = cur_kind_next;
                wr_rec.flush_form = form_of(cur_kind_next, dot_next);
            end
            cur_kind_next = KIND_NONE;
            tok_ne_next   = 1'b0;
            dot_next      = 1'b0;
            after_ws_next = 1'b0;
            in_str_next   = 1'b0;
            prior_bs_next = 1'b0;
            err_lat_next  = 1'b0;
            pos_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_kind_reg <= KIND_NONE;
            tok_ne_reg   <= 1'b0;
            dot_reg      <= 1'b0;
            after_ws_reg <= 1'b0;
            in_str_reg   <= 1'b0;
            prior_bs_reg <= 1'b0;
            err_lat_reg  <= 1'b0;
            pos_reg      <= '0;
        end
        else if (wr_en)
        begin
            cur_kind_reg <= cur_kind_next;
            tok_ne_reg   <= tok_ne_next;
            dot_reg      <= dot_next;
            after_ws_reg <= after_ws_next;
            in_str_reg   <= in_str_next;
            prior_bs_reg <= prior_bs_next;
            err_lat_reg  <= err_lat_next;
            pos_reg      <= pos_next;
        end
    end

endmodule

FILE: sv/ecl_queue.sv
// ----------------------------------------------------------------------------
// Lexer result queue
// Small FIFO of classified entries between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecl_queue #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  ecl_pkg::ecl_rec_t   wr_rec,
    input  logic                pop,
    output ecl_pkg::ecl_rec_t   head,
    output ecl_pkg::ecl_qstat_t qstat
);
    import ecl_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    ecl_rec_t         entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign qstat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head        = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entries_reg[wr_ptr_reg] <= wr_rec;
    end

endmodule

FILE: sv/ecl_back.sv
// ----------------------------------------------------------------------------
// Lexer back end
// Turns each queue entry into one or two result requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecl_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ecl_pkg::ecl_rec_t   head,
    input  ecl_pkg::ecl_qstat_t qstat,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                append,
    output logic                end_token,
    output logic [4:0]          end_kind,
    output logic [1:0]          end_form,
    output logic [4:0]          char_kind,
    output logic                error,
    output logic [4:0]          error_code,
    output logic [15:0]         column,
    output logic                last_result
);
    import ecl_pkg::*;

    typedef enum logic {
        PH_CHAR,
        PH_FLUSH
    } phase_t;

    phase_t phase_reg, phase_next;
    logic   out_acc;

    assign out_valid = !qstat.empty;
    assign out_acc   = out_valid && !out_stall;
    assign pop       = out_acc && ((phase_reg == PH_FLUSH) || !head.has_flush);

    always_comb
    begin
        column = head.column;
        case (phase_reg)
            PH_FLUSH:
            begin
                append      = 1'b0;
                end_token   = 1'b1;
                end_kind    = head.flush_kind;
                end_form    = head.flush_form;
                char_kind   = KIND_NONE;
                error       = 1'b0;
                error_code  = ERR_NONE;
                last_result = 1'b1;
            end
            default:
            begin
                append      = head.append;
                end_token   = head.end_token;
                end_kind    = head.end_kind;
                end_form    = head.end_form;
                char_kind   = head.char_kind;
                error       = head.error;
                error_code  = head.error_code;
                last_result = !head.has_flush;
            end
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (out_acc)
        begin
            case (phase_reg)
                PH_CHAR:  phase_next = head.has_flush ? PH_FLUSH : PH_CHAR;
                default:  phase_next = PH_CHAR;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_CHAR;
        else
            phase_reg <= phase_next;
    end

endmodule

FILE: sv/expression_char_lexer_core.sv
// ----------------------------------------------------------------------------
// Expression character lexer core
// Flow: an accepted character is registered into the queue and shown once its entry is at the head.
// Throughput: one character per cycle while the queue is not full; a line end that flushes a token gives two results.
// Reset: async active low, clears lexer state, queue pointers and output phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "expression_char_lexer_core_assert.svh"

module expression_char_lexer_core #(
    parameter int COLUMN_BITS = ecl_pkg::ECL_COLUMN_BITS,
    parameter int QUEUE_DEPTH = ecl_pkg::ECL_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // character requests
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  ch,
    input  logic        last,
    // result requests
    output logic        out_valid,
    input  logic        out_stall,
    output logic        append,
    output logic        end_token,
    output logic [4:0]  end_kind,
    output logic [1:0]  end_form,
    output logic [4:0]  char_kind,
    output logic        error,
    output logic [4:0]  error_code,
    output logic [15:0] column,
    output logic        last_result
);
    import ecl_pkg::*;

    // Front end: holds the whole lexer state (current kind, token/dot/
    // whitespace flags, string and escape state, column, error latch).
    // Each accepted character updates it and produces one
    // queue entry. The entry carries the character's own result and, on
    // the last character of a line, the kind and form of any token still
    // pending so the back end can emit the flush as a second result.
    ecl_rec_t   wr_rec;
    ecl_rec_t   head;
    ecl_qstat_t qstat;
    logic       wr_en;
    logic       pop;

    ecl_front #(
        .COLUMN_BITS (COLUMN_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .ch       (ch),
        .last     (last),
        .qstat    (qstat),
        .wr_en    (wr_en),
        .wr_rec   (wr_rec)
    );

    // Queue: decouples the two sides. The front only stalls when it is
    // full, so characters keep flowing while a result waits downstream.
    ecl_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (wr_en),
        .wr_rec (wr_rec),
        .pop    (pop),
        .head   (head),
        .qstat  (qstat)
    );

    // Back end: shows the head entry's character result, then its flush
    // result if it has one, and pops the entry after the final result.
    ecl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .qstat       (qstat),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .append      (append),
        .end_token   (end_token),
        .end_kind    (end_kind),
        .end_form    (end_form),
        .char_kind   (char_kind),
        .error       (error),
        .error_code  (error_code),
        .column      (column),
        .last_result (last_result)
    );

    // An illegal character neither joins nor closes a token.
    `ECL_ASSERT_IMPL(a_error_quiet, out_valid && error, !append && !end_token && (char_kind == KIND_NONE))

    // A non-final result only precedes a flush, which never follows an error.
    `ECL_ASSERT_IMPL(a_split_no_error, out_valid && !last_result, !error)

    // Once a non-final result is taken, the flush result follows at once.
    `ECL_ASSERT_NEXT(a_flush_follows, out_valid && !out_stall && !last_result, out_valid && end_token && last_result && !append)

    // Columns are one-based.
    `ECL_ASSERT_IMPL(a_column_nonzero, out_valid, column != '0)

endmodule

FILE: test/tb_expression_char_lexer_core.sv
// ----------------------------------------------------------------------------
// Expression character lexer core testbench
// Streams source lines one character per request into the lexer and checks
// every result against an in-bench lexer model: token closes, kinds, forms,
// complaint codes, column count and the line-end flush. Both request channels
// idle at random, with a long receiver hold and a full drain along the way.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_expression_char_lexer_core;

    import ecl_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int LONG_HOLD       = 100;
    localparam int REPORT_LIMIT    = 10;

    // one result request as seen on the output channel
    typedef struct packed {
        logic        append;
        logic        end_token;
        kind_t       end_kind;
        form_t       end_form;
        kind_t       char_kind;
        logic        error;
        err_t        error_code;
        logic [15:0] column;
        logic        last_result;
    } lex_res_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  ch;
    logic        last;
    logic        out_valid;
    logic        out_stall;
    logic        append;
    logic        end_token;
    logic [4:0]  end_kind;
    logic [1:0]  end_form;
    logic [4:0]  char_kind;
    logic        error;
    logic [4:0]  error_code;
    logic [15:0] column;
    logic        last_result;

    // character sets used both for classification and for building lines
    string op_chars     = "+-*!/=><@";
    string digit_chars  = "0123456789";
    string word_chars   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_:";
    string sing_chars   = ".,()[]{}|&~;";
    string blank_chars  = " \t";
    string string_chars = "ab.7\\ ";

    // lexer model state
    kind_t       cur_kind     = KIND_NONE;
    logic        tok_busy     = 1'b0;
    logic        dot_seen     = 1'b0;
    logic        after_ws     = 1'b0;
    logic        in_str       = 1'b0;
    logic        prev_bslash  = 1'b0;
    logic        err_latched  = 1'b0;
    logic [15:0] col_count    = 16'd0;

    lex_res_t    expected_q[$];
    logic [7:0]  line_buf[$];

    // traffic control shared between the sequence and the two channel processes
    bit          src_gaps  = 1'b1;
    bit          sink_gaps = 1'b1;
    bit          long_hold = 1'b0;

    int          mismatches    = 0;
    int          results_seen  = 0;
    int          tokens_closed = 0;
    int          errors_seen   = 0;
    int          chars_sent    = 0;
    int          live_chars    = 0;
    int          lines_sent    = 0;
    int          quiet_cycles  = 0;

    expression_char_lexer_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .ch          (ch),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .append      (append),
        .end_token   (end_token),
        .end_kind    (end_kind),
        .end_form    (end_form),
        .char_kind   (char_kind),
        .error       (error),
        .error_code  (error_code),
        .column      (column),
        .last_result (last_result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Lexer model
    // ------------------------------------------------------------------------

    // position of c in set, -1 when absent
    function automatic int set_index(string set, logic [7:0] c);
        for (int i = 0; i < set.len(); i++)
        begin
            if (set[i] == c)
                return i;
        end
        return -1;
    endfunction

    function automatic logic [7:0] pick(string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    function automatic form_t number_form(kind_t k);
        if (k != KIND_NUMSTR)
            return FORM_PLAIN;
        return dot_seen ? FORM_FLOAT : FORM_INT;
    endfunction

    // Kind of c following a token of kind prev; -1 and a complaint if illegal.
    function automatic int classify(logic [7:0] c, kind_t prev, output err_t code);
        flags_t      fl;
        logic [11:0] allow;
        int          s;
        code = ERR_NONE;
        if (c == CH_SPACE || c == CH_TAB)
            return KIND_NONE;
        if (c == CH_NL)
            return KIND_SOFT_END;
        // what may follow each kind: class flags, allowed singulars, complaint
        case (prev)
            KIND_TEXT:       begin fl = FL_TXT;                allow = 12'h9FF; code = ERR_TEXT;       end
            KIND_NUMSTR:     begin fl = FL_NUM;                allow = 12'h9EB; code = ERR_NUMSTR;     end
            KIND_OPER:       begin fl = FL_OP | FL_DG | FL_WD; allow = 12'hE57; code = ERR_OPER;       end
            KIND_ACCESSOR:   begin fl = FL_WD;                 allow = 12'h000; code = ERR_ACCESSOR;   end
            KIND_DELIM:      begin fl = FL_OP | FL_DG | FL_WD; allow = 12'h61C; code = ERR_DELIM;      end
            KIND_ARG_START:  begin fl = FL_OP | FL_DG | FL_WD; allow = 12'h61C; code = ERR_ARG_START;  end
            KIND_ARG_END:    begin fl = FL_OP | FL_WD;         allow = 12'h9FF; code = ERR_CLOSER;     end
            KIND_IND_START:  begin fl = FL_OP | FL_DG | FL_WD; allow = 12'h677; code = ERR_IND_START;  end
            KIND_IND_END:    begin fl = FL_OP;                 allow = 12'hDFF; code = ERR_IND_END;    end
            KIND_CTRL_START: begin fl = FL_OP | FL_DG | FL_WD; allow = 12'h794; code = ERR_CTRL_START; end
            KIND_CTRL_END:   begin fl = FL_OP | FL_WD;         allow = 12'h9FF; code = ERR_CLOSER;     end
            KIND_PIPE:       begin fl = FL_OP | FL_DG | FL_WD; allow = 12'h614; code = ERR_PIPE;       end
            KIND_PIPE_RES:   begin fl = FL_OP;                 allow = 12'hBFF; code = ERR_PIPE_RES;   end
            KIND_SPREAD:     begin fl = FL_WD;                 allow = 12'h257; code = ERR_SPREAD;     end
            KIND_STMT_END:   begin fl = FL_OP | FL_DG | FL_WD; allow = 12'hCD4; code = ERR_STMT_END;   end
            KIND_SOFT_END:   begin fl = FL_OP | FL_DG | FL_WD; allow = 12'hFFF; code = ERR_SOFT_END;   end
            default:         begin fl = FL_OP | FL_DG | FL_WD; allow = 12'h414; code = ERR_NONE;       end
        endcase
        if ((fl & FL_NUM) != 0)
        begin
            if (c == CH_DOT && dot_seen)
            begin
                code = ERR_DOT;
                return -1;
            end
            if (set_index(digit_chars, c) >= 0 || c == CH_DOT)
                return KIND_NUMSTR;
            if (set_index(op_chars, c) >= 0)
                return KIND_OPER;
        end
        else if ((fl & FL_TXT) != 0)
        begin
            // a digit right after whitespace starts a number even after text
            if (after_ws && set_index(digit_chars, c) >= 0)
                return KIND_NUMSTR;
            if (set_index(word_chars, c) >= 0 || set_index(digit_chars, c) >= 0)
                return KIND_TEXT;
            if (set_index(op_chars, c) >= 0)
                return KIND_OPER;
        end
        else
        begin
            if ((fl & FL_OP) != 0 && set_index(op_chars, c) >= 0)
                return KIND_OPER;
            if ((fl & FL_DG) != 0 && set_index(digit_chars, c) >= 0)
                return KIND_NUMSTR;
            if ((fl & FL_WD) != 0 && set_index(word_chars, c) >= 0)
                return KIND_TEXT;
        end
        s = set_index(sing_chars, c);
        if (s >= 0 && allow[s])
            return int'(KIND_ACCESSOR) + s;
        return -1;
    endfunction

    task automatic close_token(inout lex_res_t r, input kind_t k, input form_t f);
        r.end_token = 1'b1;
        r.end_kind  = k;
        r.end_form  = f;
        tok_busy    = 1'b0;
        dot_seen    = 1'b0;
    endtask

    // Append one expected result at the tail of the scoreboard.
    function automatic void queue_result(lex_res_t r);
        expected_q.insert(expected_q.size(), r);
    endfunction

    // Advance the model by one accepted character and queue its results.
    task automatic predict_char(input logic [7:0] c, input logic is_last);
        lex_res_t r;
        lex_res_t flush;
        err_t     code;
        int       k;
        logic     sing;
        if (col_count != 16'hFFFF)
            col_count++;
        r = '0;
        r.column = col_count;
        if (!err_latched)
        begin
            live_chars++;
            if (c == CH_QUOTE && !in_str)
            begin
                // opening quote closes whatever was pending
                if (tok_busy)
                    close_token(r, cur_kind, number_form(cur_kind));
                in_str      = 1'b1;
                cur_kind    = KIND_NUMSTR;
                tok_busy    = 1'b0;
                dot_seen    = 1'b0;
                r.char_kind = KIND_NUMSTR;
            end
            else if (c == CH_QUOTE && in_str && !prev_bslash)
            begin
                in_str = 1'b0;
                close_token(r, KIND_NUMSTR, FORM_STRING);
                r.char_kind = KIND_NUMSTR;
            end
            else if (in_str)
            begin
                // backslashes are swallowed, everything else is string text
                r.char_kind = KIND_NUMSTR;
                if (c != CH_BSLASH)
                begin
                    r.append = 1'b1;
                    tok_busy = 1'b1;
                    if (c == CH_DOT)
                        dot_seen = 1'b1;
                end
            end
            else
            begin
                k = classify(c, cur_kind, code);
                if (k < 0)
                begin
                    // pending token is dropped, rest of line ignored
                    r.error      = 1'b1;
                    r.error_code = code;
                    err_latched  = 1'b1;
                end
                else if (k == KIND_NONE)
                begin
                    after_ws = 1'b1;
                    if (tok_busy)
                        close_token(r, cur_kind, number_form(cur_kind));
                end
                else
                begin
                    sing     = set_index(sing_chars, c) >= 0 && c != CH_DOT;
                    after_ws = 1'b0;
                    if ((kind_t'(k) != cur_kind || sing) && cur_kind != KIND_NONE && tok_busy)
                        close_token(r, cur_kind, number_form(cur_kind));
                    cur_kind = kind_t'(k);
                    tok_busy = 1'b1;
                    if (c == CH_DOT)
                        dot_seen = 1'b1;
                    r.append    = 1'b1;
                    r.char_kind = kind_t'(k);
                end
            end
        end
        prev_bslash = (c == CH_BSLASH);

        if (is_last && !err_latched && tok_busy)
        begin
            // line end with a token still open: second result flushes it
            flush = '0;
            flush.column = col_count;
            close_token(flush, cur_kind, number_form(cur_kind));
            flush.last_result = 1'b1;
            queue_result(r);
            queue_result(flush);
        end
        else
        begin
            r.last_result = 1'b1;
            queue_result(r);
        end

        if (is_last)
        begin
            cur_kind    = KIND_NONE;
            tok_busy    = 1'b0;
            dot_seen    = 1'b0;
            after_ws    = 1'b0;
            in_str      = 1'b0;
            prev_bslash = 1'b0;
            err_latched = 1'b0;
            col_count   = 16'd0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Character channel
    // ------------------------------------------------------------------------

    // Offer one character request and hold it until the lexer takes it.
    task automatic send_char(input logic [7:0] c, input logic is_last);
        if (src_gaps && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        ch       <= c;
        last     <= is_last;
        do
            @(posedge clk);
        while (in_stall);
        predict_char(c, is_last);
        chars_sent++;
        if (is_last)
            lines_sent++;
    endtask

    // Append one character to the line being built.
    function automatic void add_char(logic [7:0] c);
        line_buf.insert(line_buf.size(), c);
    endfunction

    task automatic send_buffered_line();
        for (int i = 0; i < line_buf.size(); i++)
            send_char(line_buf[i], i == line_buf.size() - 1);
    endtask

    task automatic send_text(input string s);
        line_buf.delete();
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
        send_buffered_line();
    endtask

    // Drop valid and wait until every queued result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Build one line in line_buf. Mostly token-shaped fragments so lines get
    // past the first character; some pure noise and some corrupted lines.
    task automatic compose_line();
        line_buf.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 6))
                add_char(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(1, 6))
        begin
            case ($urandom_range(0, 9))
                0, 1:
                    repeat ($urandom_range(1, 3))
                        add_char(pick(word_chars));
                2:
                begin
                    repeat ($urandom_range(1, 2))
                        add_char(pick(digit_chars));
                    if ($urandom_range(0, 1) == 1)
                    begin
                        add_char(CH_DOT);
                        add_char(pick(digit_chars));
                    end
                end
                3:
                    repeat ($urandom_range(1, 2))
                        add_char(pick(op_chars));
                4:
                    add_char(pick(sing_chars));
                5:
                    add_char(pick(blank_chars));
                6:
                begin
                    // string literal, sometimes with an escaped quote, sometimes open
                    add_char(CH_QUOTE);
                    repeat ($urandom_range(0, 3))
                        add_char(pick(string_chars));
                    if ($urandom_range(0, 3) == 0)
                    begin
                        add_char(CH_BSLASH);
                        add_char(CH_QUOTE);
                    end
                    if ($urandom_range(0, 4) != 0)
                        add_char(CH_QUOTE);
                end
                7:
                    add_char(CH_NL);
                8:
                begin
                    add_char(CH_DOT);
                    add_char(pick(word_chars));
                end
                default:
                begin
                    add_char(CH_SPACE);
                    add_char(pick(digit_chars));
                end
            endcase
        end
        if ($urandom_range(0, 9) == 0)
            line_buf.insert($urandom_range(0, line_buf.size() - 1),
                            8'($urandom_range(0, 255)));
    endtask

    // Send random lines until about n characters were actually lexed.
    task automatic send_random_chars(input int n);
        int target;
        target = live_chars + n;
        while (live_chars < target)
        begin
            compose_line();
            send_buffered_line();
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_directed_lines();
        send_text("a.b+1.5");                   // accessor, operator, float flush at line end
        send_text("x\"\\\".\"\"\"");            // quote closes text, escaped quote, empty string
        send_text("\"1.5");                     // open string flushed as a float
        send_text("1..z");                      // second dot, rest of line ignored
        send_text("a $b");                      // unknown byte after text
        send_char(8'h00, 1'b1);                 // unknown byte at start of line
        send_char(8'h28, 1'b0);                 // '(' then top byte value
        send_char(8'hFF, 1'b1);
        send_text("\t1\n");                     // tab, integer closed by newline, newline flushed
    endtask

    // Receiver holds off while characters are offered until the queue fills, then a full drain.
    task automatic test_backpressure();
        long_hold = 1'b1;
        send_random_chars(30);
        wait_drained();
    endtask

    task automatic test_random_lines();
        send_random_chars(250);
    endtask

    // Last stretch runs with both channels streaming back to back.
    task automatic test_quiet_tail();
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        send_random_chars(60);
    endtask

    // ------------------------------------------------------------------------
    // Result channel: stall pattern and checking
    // ------------------------------------------------------------------------

    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 1'b0;
                out_stall <= 1'b0;
            end
            else if (sink_gaps && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic string show(lex_res_t r);
        return $sformatf("app=%0d end=%0d kind=%0d form=%0d ckind=%0d err=%0d code=%0d col=%0d lr=%0d",
                         r.append, r.end_token, r.end_kind, r.end_form, r.char_kind,
                         r.error, r.error_code, r.column, r.last_result);
    endfunction

    always @(posedge clk)
    begin
        lex_res_t got;
        lex_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{append, end_token, end_kind, end_form, char_kind,
                    error, error_code, column, last_result};
            results_seen++;
            if (got.end_token)
                tokens_closed++;
            if (got.error)
                errors_seen++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result %s", $realtime, show(got));
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("%0t: result mismatch", $realtime);
                        $display("    expected %s", show(want));
                        $display("    actual   %s", show(got));
                    end
                end
            end
        end
    end

    // Watchdog: too long with neither channel moving ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("timeout: no request moved for %0d cycles", WATCHDOG_CYCLES);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        ch       <= 8'h00;
        last     <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_lines();
        test_backpressure();
        test_random_lines();
        test_quiet_tail();

        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Lexed %0d characters over %0d lines, with a long output hold and a drain.",
                 chars_sent, lines_sent);
        $display("Checked %0d results: %0d tokens closed, %0d errors, %0d mismatches.",
                 results_seen, tokens_closed, errors_seen, mismatches);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/ecl_pkg.sv
sv/ecl_front.sv
sv/ecl_queue.sv
sv/ecl_back.sv
sv/expression_char_lexer_core.sv
test/tb_expression_char_lexer_core.sv
